[rtl/vca_pkg.sv]
// vca_pkg: types, register map and a helper function of the voltage controlled amplifier
// no dependencies; imported by every module of the block
`default_nettype none

package vca_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [15:0] ONE_Q15 = 16'h8000;

	// register indexes
	localparam logic [2:0] REG_CONTROL_MODE     = 3'd0;
	localparam logic [2:0] REG_AUDIO_MODE       = 3'd1;
	localparam logic [2:0] REG_MASTER_ENABLE    = 3'd2;
	localparam logic [2:0] REG_CONTROL_BALANCE  = 3'd3;
	localparam logic [2:0] REG_CONTROL_STRENGTH = 3'd4;
	localparam logic [2:0] REG_PRE_GAIN         = 3'd5;
	localparam logic [2:0] REG_AUDIO_WEIGHT     = 3'd6;
	localparam logic [2:0] REG_OUT_GAIN         = 3'd7;

	// control modes
	localparam logic [2:0] CM_FIXED    = 3'd0;
	localparam logic [2:0] CM_BALANCED = 3'd1;
	localparam logic [2:0] CM_PRODUCT  = 3'd2;
	localparam logic [2:0] CM_ONE      = 3'd3;
	localparam logic [2:0] CM_TWO      = 3'd4;

	// audio modes
	localparam logic [1:0] AM_BALANCED = 2'd0;
	localparam logic [1:0] AM_ONE      = 2'd1;
	localparam logic [1:0] AM_TWO      = 2'd2;

	typedef struct packed {
		logic [2:0]  control_mode;
		logic [1:0]  audio_mode;
		logic        master_enable;
		logic [15:0] control_balance;
		logic [15:0] control_strength;
		logic [15:0] pre_gain;
		logic [15:0] audio_weight;
		logic [15:0] out_gain;
	} cfg_t;

	// word between the mix and gain stages
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [14:0]        level;
		logic signed [15:0] audio;
	} mix_word_t;

	function automatic logic [15:0] sat_one(input logic [15:0] v);
		return (v > ONE_Q15) ? ONE_Q15 : v;
	endfunction

endpackage

`default_nettype wire

[rtl/voltage_controlled_amplifier_core.sv]
// voltage_controlled_amplifier_core: top level of the voltage controlled amplifier
// depends on vca_pkg, vca_regs, vca_mix and vca_gain
`default_nettype none

// usage
//  - a sample word (two controls, two audio samples, block_last) is taken at
//    each rising edge where start is high and busy is low; busy stays low,
//    so a new word can be issued in every cycle
//  - each word gives one result: amplified and block_end, shown for one
//    cycle with done high once the word has passed all register stages
//  - throughput is one word per cycle; a word passes the five register
//    stages: mixing products, mix reduction, level scaling and master gain
//    product, final level product, saturation
//  - results cannot be held off; done words must be captured when shown
//  - the apb port writes and reads the eight settings at byte address 4*i;
//    the user must change settings only with no words in flight; not enforced
//  - arst_n clears the pipeline valid bits and loads the default settings
module voltage_controlled_amplifier_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [vca_pkg::ADDR_W-1:0] paddr,
	input  wire logic [vca_pkg::DATA_W-1:0] pwdata,
	output      logic [vca_pkg::DATA_W-1:0] prdata,
	output      logic                       pready,
	input  wire logic                       start,
	output      logic                       busy,
	input  wire logic signed [15:0]         control_one,
	input  wire logic signed [15:0]         control_two,
	input  wire logic signed [15:0]         audio_one,
	input  wire logic signed [15:0]         audio_two,
	input  wire logic                       block_last,
	output      logic                       done,
	output      logic signed [15:0]         amplified,
	output      logic                       block_end
);
	import vca_pkg::*;

	cfg_t      cfg;
	mix_word_t mix;
	logic      accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	vca_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vca_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (accept),
		.control_one (control_one),
		.control_two (control_two),
		.audio_one   (audio_one),
		.audio_two   (audio_two),
		.block_last  (block_last),
		.mix         (mix)
	);

	vca_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mix       (mix),
		.done      (done),
		.amplified (amplified),
		.block_end (block_end)
	);

endmodule

`default_nettype wire

[rtl/vca_regs.sv]
// vca_regs: apb configuration registers of the amplifier
// depends on vca_pkg
`default_nettype none

module vca_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [vca_pkg::ADDR_W-1:0] paddr,
	input  wire logic [vca_pkg::DATA_W-1:0] pwdata,
	output      logic [vca_pkg::DATA_W-1:0] prdata,
	output      logic                       pready,
	output      vca_pkg::cfg_t              cfg
);
	import vca_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_mode     <= CM_BALANCED;
			cfg_q.audio_mode       <= AM_BALANCED;
			cfg_q.master_enable    <= 1'b1;
			cfg_q.control_balance  <= 16'd16384;
			cfg_q.control_strength <= 16'd32768;
			cfg_q.pre_gain         <= 16'd0;
			cfg_q.audio_weight     <= 16'd16384;
			cfg_q.out_gain         <= 16'd16384;
		end else if (wr_en) begin
			unique case (idx)
				REG_CONTROL_MODE:     cfg_q.control_mode     <= pwdata[2:0];
				REG_AUDIO_MODE:       cfg_q.audio_mode       <= pwdata[1:0];
				REG_MASTER_ENABLE:    cfg_q.master_enable    <= pwdata[0];
				REG_CONTROL_BALANCE:  cfg_q.control_balance  <= pwdata[15:0];
				REG_CONTROL_STRENGTH: cfg_q.control_strength <= pwdata[15:0];
				REG_PRE_GAIN:         cfg_q.pre_gain         <= pwdata[15:0];
				REG_AUDIO_WEIGHT:     cfg_q.audio_weight     <= pwdata[15:0];
				REG_OUT_GAIN:         cfg_q.out_gain         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CONTROL_MODE:     prdata[2:0]  = cfg_q.control_mode;
			REG_AUDIO_MODE:       prdata[1:0]  = cfg_q.audio_mode;
			REG_MASTER_ENABLE:    prdata[0]    = cfg_q.master_enable;
			REG_CONTROL_BALANCE:  prdata[15:0] = cfg_q.control_balance;
			REG_CONTROL_STRENGTH: prdata[15:0] = cfg_q.control_strength;
			REG_PRE_GAIN:         prdata[15:0] = cfg_q.pre_gain;
			REG_AUDIO_WEIGHT:     prdata[15:0] = cfg_q.audio_weight;
			REG_OUT_GAIN:         prdata[15:0] = cfg_q.out_gain;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[rtl/vca_mix.sv]
// vca_mix: stages 1 and 2, control and audio mixing products and their reduction
// depends on vca_pkg
`default_nettype none

module vca_mix (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vca_pkg::cfg_t      cfg,
	input  wire logic               in_valid,
	input  wire logic signed [15:0] control_one,
	input  wire logic signed [15:0] control_two,
	input  wire logic signed [15:0] audio_one,
	input  wire logic signed [15:0] audio_two,
	input  wire logic               block_last,
	output      vca_pkg::mix_word_t mix
);
	import vca_pkg::*;

	logic [15:0]        cw1, cw2, aw1, aw2;
	logic signed [16:0] cop1, cop2, aop1, aop2;
	logic signed [32:0] pc1, pc2, pa1, pa2;
	logic               pos;

	logic               valid_s1, last_s1, pos_s1;
	logic signed [32:0] pc1_s1, pc2_s1, pa1_s1, pa2_s1;

	logic signed [33:0] csum, asum;
	logic               czero;

	logic               valid_s2, last_s2;
	logic [14:0]        level_s2;
	logic signed [15:0] audio_s2;

	assign cw2 = sat_one(cfg.control_balance);
	assign cw1 = ONE_Q15 - cw2;
	assign aw2 = sat_one(cfg.audio_weight);
	assign aw1 = ONE_Q15 - aw2;

	always_comb begin
		cop1 = '0;
		cop2 = '0;
		unique case (cfg.control_mode)
			CM_BALANCED: begin
				cop1 = signed'({1'b0, cw1});
				cop2 = signed'({1'b0, cw2});
			end
			CM_PRODUCT: cop1 = signed'({control_two[15], control_two});
			CM_ONE:     cop1 = signed'({1'b0, ONE_Q15});
			CM_TWO:     cop2 = signed'({1'b0, ONE_Q15});
			default: ;
		endcase
	end

	always_comb begin
		aop1 = signed'({1'b0, aw1});
		aop2 = signed'({1'b0, aw2});
		unique case (cfg.audio_mode)
			AM_ONE: begin
				aop1 = signed'({1'b0, ONE_Q15});
				aop2 = '0;
			end
			AM_TWO: begin
				aop1 = '0;
				aop2 = signed'({1'b0, ONE_Q15});
			end
			default: ;
		endcase
	end

	assign pc1 = control_one * cop1;
	assign pc2 = control_two * cop2;
	assign pa1 = audio_one * aop1;
	assign pa2 = audio_two * aop2;
	assign pos = (control_one > 16'sd0) && (control_two > 16'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pc1_s1  <= pc1;
		pc2_s1  <= pc2;
		pa1_s1  <= pa1;
		pa2_s1  <= pa2;
		pos_s1  <= pos;
		last_s1 <= block_last;
	end

	assign csum  = 34'(pc1_s1) + 34'(pc2_s1);
	assign asum  = 34'(pa1_s1) + 34'(pa2_s1);
	// negative level, or a product with a non-positive control, gives zero
	assign czero = csum[33] | ((cfg.control_mode == CM_PRODUCT) & ~pos_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		level_s2 <= czero ? 15'd0 : csum[29:15];
		audio_s2 <= asum[30:15];
		last_s2  <= last_s1;
	end

	assign mix.valid = valid_s2;
	assign mix.last  = last_s2;
	assign mix.level = level_s2;
	assign mix.audio = audio_s2;

endmodule

`default_nettype wire

[rtl/vca_gain.sv]
// vca_gain: stages 3 to 5, level scaling, gain products and output saturation
// depends on vca_pkg
`default_nettype none

module vca_gain (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vca_pkg::cfg_t      cfg,
	input  wire vca_pkg::mix_word_t mix,
	output      logic               done,
	output      logic signed [15:0] amplified,
	output      logic               block_end
);
	import vca_pkg::*;

	logic [30:0]        sprod;
	logic [16:0]        lsum;
	logic [15:0]        level;
	logic signed [32:0] scaled;

	logic               valid_s3, last_s3;
	logic [15:0]        level_s3;
	logic signed [32:0] scaled_s3;

	logic signed [49:0] prod;
	logic               valid_s4, last_s4;
	logic signed [49:0] prod_s4;

	logic signed [20:0] shifted;
	logic signed [15:0] sat;

	logic               valid_s5, last_s5;
	logic signed [15:0] amp_s5;

	assign sprod = 31'(mix.level) * 31'(sat_one(cfg.control_strength));
	assign lsum  = {1'b0, sprod[30:15]} + {1'b0, sat_one(cfg.pre_gain)};
	assign level = (lsum > {1'b0, ONE_Q15}) ? ONE_Q15 : lsum[15:0];

	// master gain is Q2.14; without it the audio is lined up to the same scale
	assign scaled = cfg.master_enable ? (mix.audio * signed'({1'b0, cfg.out_gain}))
	                                  : signed'({{3{mix.audio[15]}}, mix.audio, 14'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s3 <= mix.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		level_s3  <= level;
		scaled_s3 <= scaled;
		last_s3   <= mix.last;
	end

	assign prod = signed'({1'b0, level_s3}) * scaled_s3;

	always_ff @(posedge clk) begin
		prod_s4 <= prod;
		last_s4 <= last_s3;
	end

	assign shifted = prod_s4[49:29];

	always_comb begin
		priority if (shifted > 21'sd32767) begin
			sat = 16'sh7fff;
		end else if (shifted < -21'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = shifted[15:0];
		end
	end

	always_ff @(posedge clk) begin
		amp_s5  <= sat;
		last_s5 <= last_s4;
	end

	assign done      = valid_s5;
	assign amplified = amp_s5;
	assign block_end = last_s5;

endmodule

`default_nettype wire

[tb/tb_voltage_controlled_amplifier_core.sv]
`timescale 1ns / 1ps
// tb_voltage_controlled_amplifier_core: self-checking testbench of the voltage controlled amplifier core
// depends on vca_pkg and voltage_controlled_amplifier_core; a directed table, then random phases,
// every result checked: amplified against a bit-exact predictor or a typed table value, and block_end

module tb_voltage_controlled_amplifier_core;
	import vca_pkg::*;

	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int DRAIN_CYCLES    = 16;
	localparam int PHASES          = 10;
	localparam int WORDS_PER_PHASE = 80;
	localparam int QUIET_PHASE     = 4;

	// mode codes with no function of their own
	localparam logic [2:0] CM_UNUSED = 3'd5;
	localparam logic [1:0] AM_UNUSED = 2'd3;

	typedef struct {
		logic signed [15:0] control_one;
		logic signed [15:0] control_two;
		logic signed [15:0] audio_one;
		logic signed [15:0] audio_two;
		logic               block_last;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] amplified;
		logic               block_end;
	} result_t;

	typedef enum logic {ROW_WORD, ROW_SETTING} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [2:0]         index;
		logic [15:0]        value;
		sample_t            word;
		bit                 typed;
		logic signed [15:0] amplified;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic signed [15:0]  control_one;
	logic signed [15:0]  control_two;
	logic signed [15:0]  audio_one;
	logic signed [15:0]  audio_two;
	logic                block_last;
	logic                done;
	logic signed [15:0]  amplified;
	logic                block_end;

	cfg_t    amp_settings;
	result_t pending_results[$];
	int      failures;
	int      idle_cycles;

	voltage_controlled_amplifier_core u_dut (.*);

	always #5 clk = ~clk;

	function automatic longint clamp_unity(logic [15:0] v);
		return (v > ONE_Q15) ? longint'(ONE_Q15) : longint'(v);
	endfunction

	function automatic logic signed [15:0] amplify(cfg_t s, sample_t w);
		longint c1, c2, a1, a2, gain, weight, level, au, p;
		bit     controlled;
		c1 = w.control_one;
		c2 = w.control_two;
		a1 = w.audio_one;
		a2 = w.audio_two;
		gain = clamp_unity(s.pre_gain);
		controlled = 1'b1;
		level = 0;
		case (s.control_mode)
			CM_BALANCED: begin
				weight = clamp_unity(s.control_balance);
				level = ((32768 - weight) * c1 + weight * c2) >>> 15;
			end
			CM_PRODUCT: level = (c1 > 0 && c2 > 0) ? (c1 * c2) >>> 15 : 0;
			CM_ONE:     level = c1;
			CM_TWO:     level = c2;
			default:    controlled = 1'b0;
		endcase
		if (controlled) begin
			level = (level < 0) ? 0 : (level * clamp_unity(s.control_strength)) >>> 15;
			level = level + gain;
		end else begin
			level = gain;
		end
		if (level > 32768)
			level = 32768;
		case (s.audio_mode)
			AM_ONE: au = a1;
			AM_TWO: au = a2;
			default: begin
				weight = clamp_unity(s.audio_weight);
				au = ((32768 - weight) * a1 + weight * a2) >>> 15;
			end
		endcase
		p = level * au;
		if (s.master_enable)
			p = (p * longint'(s.out_gain)) >>> 29;
		else
			p = p >>> 15;
		if (p > 32767)
			p = 32767;
		if (p < -32768)
			p = -32768;
		return p[15:0];
	endfunction

	function automatic row_t setting_row(logic [2:0] index, logic [15:0] value);
		row_t r;
		r.kind = ROW_SETTING;
		r.index = index;
		r.value = value;
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic row_t word_row(logic signed [15:0] c1, logic signed [15:0] c2,
			logic signed [15:0] a1, logic signed [15:0] a2, logic last,
			bit typed, logic signed [15:0] amp);
		row_t r;
		r.kind = ROW_WORD;
		r.word.control_one = c1;
		r.word.control_two = c2;
		r.word.audio_one = a1;
		r.word.audio_two = a2;
		r.word.block_last = last;
		r.typed = typed;
		r.amplified = amp;
		return r;
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return 16'($urandom_range(0, 8)) - 16'sd4;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_q15();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return ONE_Q15;
			2: return 16'hffff;
			3: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [15:0] pick_master();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'd16384;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic issue_word(sample_t w, bit typed, logic signed [15:0] typed_amp);
		result_t r;
		start <= 1'b1;
		control_one <= w.control_one;
		control_two <= w.control_two;
		audio_one <= w.audio_one;
		audio_two <= w.audio_two;
		block_last <= w.block_last;
		do @(posedge clk); while (busy);
		r.amplified = typed ? typed_amp : amplify(amp_settings, w);
		r.block_end = w.block_last;
		pending_results.push_back(r);
	endtask

	// when allowed, each cycle idles with a chance of about 35 in 100
	task automatic maybe_idle(bit allowed);
		while (allowed && $urandom_range(0, 99) < 35) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold the sender off until every word in flight has come out
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_setting(logic [2:0] index, logic [15:0] value);
		settle();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({index, 2'b00});
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_CONTROL_MODE:     amp_settings.control_mode = value[2:0];
			REG_AUDIO_MODE:       amp_settings.audio_mode = value[1:0];
			REG_MASTER_ENABLE:    amp_settings.master_enable = value[0];
			REG_CONTROL_BALANCE:  amp_settings.control_balance = value;
			REG_CONTROL_STRENGTH: amp_settings.control_strength = value;
			REG_PRE_GAIN:         amp_settings.pre_gain = value;
			REG_AUDIO_WEIGHT:     amp_settings.audio_weight = value;
			REG_OUT_GAIN:         amp_settings.out_gain = value;
			default: ;
		endcase
	endtask

	initial begin : stimulus
		row_t    script[$];
		sample_t w;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		control_one = '0;
		control_two = '0;
		audio_one = '0;
		audio_two = '0;
		block_last = 1'b0;
		failures = 0;
		amp_settings.control_mode = CM_BALANCED;
		amp_settings.audio_mode = AM_BALANCED;
		amp_settings.master_enable = 1'b1;
		amp_settings.control_balance = 16'd16384;
		amp_settings.control_strength = ONE_Q15;
		amp_settings.pre_gain = 16'd0;
		amp_settings.audio_weight = 16'd16384;
		amp_settings.out_gain = 16'd16384;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: balanced controls, unity strength, no pregain
		script.push_back(word_row(0, 0, 32767, 32767, 1, 1, 0));
		script.push_back(word_row(32767, 32767, 32767, 32767, 0, 0, 0));
		script.push_back(word_row(-32768, -32768, -32768, -32768, 1, 1, 0));
		script.push_back(word_row(32767, -32768, -32768, 32767, 0, 0, 0));
		// fixed gain at one, straight through
		script.push_back(setting_row(REG_CONTROL_MODE, CM_FIXED));
		script.push_back(setting_row(REG_PRE_GAIN, ONE_Q15));
		script.push_back(setting_row(REG_MASTER_ENABLE, 16'd0));
		script.push_back(setting_row(REG_AUDIO_MODE, AM_ONE));
		script.push_back(word_row(5, 5, 32767, -32768, 1, 1, 32767));
		script.push_back(word_row(5, 5, -32768, 32767, 0, 1, -32768));
		script.push_back(word_row(5, 5, 0, 32767, 1, 1, 0));
		// full master gain saturates
		script.push_back(setting_row(REG_MASTER_ENABLE, 16'd1));
		script.push_back(setting_row(REG_OUT_GAIN, 16'hffff));
		script.push_back(word_row(0, 0, 32767, 0, 0, 1, 32767));
		script.push_back(word_row(0, 0, -32768, 0, 1, 1, -32768));
		// pregain above one
		script.push_back(setting_row(REG_PRE_GAIN, 16'hffff));
		script.push_back(word_row(0, 0, 16384, 0, 0, 0, 0));
		script.push_back(setting_row(REG_AUDIO_MODE, AM_TWO));
		script.push_back(word_row(0, 0, 32767, -1, 1, 0, 0));
		script.push_back(setting_row(REG_AUDIO_MODE, AM_UNUSED));
		script.push_back(word_row(0, 0, 12345, -23456, 0, 0, 0));
		// product mode, positive controls, then non-positive control gives zero
		script.push_back(setting_row(REG_PRE_GAIN, 16'd0));
		script.push_back(setting_row(REG_CONTROL_MODE, CM_PRODUCT));
		script.push_back(setting_row(REG_OUT_GAIN, 16'd16384));
		script.push_back(word_row(32767, 32767, 20000, -20000, 1, 0, 0));
		script.push_back(word_row(-1, 32767, 20000, -20000, 0, 1, 0));
		script.push_back(word_row(0, 5, 20000, -20000, 1, 1, 0));
		// single controls, strength above one and zero, then an unused control mode
		script.push_back(setting_row(REG_CONTROL_MODE, CM_ONE));
		script.push_back(setting_row(REG_CONTROL_STRENGTH, 16'hffff));
		script.push_back(word_row(32767, -32768, 30000, 30000, 0, 0, 0));
		script.push_back(word_row(-32768, 32767, 30000, 30000, 1, 1, 0));
		script.push_back(setting_row(REG_CONTROL_MODE, CM_TWO));
		script.push_back(setting_row(REG_CONTROL_STRENGTH, 16'd0));
		script.push_back(word_row(0, 32767, 30000, 30000, 0, 1, 0));
		script.push_back(setting_row(REG_PRE_GAIN, 16'd16384));
		script.push_back(setting_row(REG_CONTROL_MODE, CM_UNUSED));
		script.push_back(word_row(32767, 32767, -30000, 30000, 1, 0, 0));
		// balance weights above one, then zero
		script.push_back(setting_row(REG_CONTROL_MODE, CM_BALANCED));
		script.push_back(setting_row(REG_CONTROL_STRENGTH, ONE_Q15));
		script.push_back(setting_row(REG_CONTROL_BALANCE, 16'hffff));
		script.push_back(setting_row(REG_AUDIO_WEIGHT, 16'hffff));
		script.push_back(word_row(-32768, 32767, 32767, -32768, 0, 0, 0));
		script.push_back(setting_row(REG_CONTROL_BALANCE, 16'd0));
		script.push_back(setting_row(REG_AUDIO_WEIGHT, 16'd0));
		script.push_back(word_row(-32768, 32767, 32767, -32768, 1, 0, 0));

		foreach (script[i]) begin
			if (script[i].kind == ROW_SETTING) begin
				write_setting(script[i].index, script[i].value);
			end else begin
				issue_word(script[i].word, script[i].typed, script[i].amplified);
				maybe_idle(1'b1);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			write_setting(REG_CONTROL_MODE, 16'($urandom_range(0, 7)));
			write_setting(REG_AUDIO_MODE, 16'($urandom_range(0, 3)));
			write_setting(REG_MASTER_ENABLE, 16'($urandom_range(0, 1)));
			write_setting(REG_CONTROL_BALANCE, pick_q15());
			write_setting(REG_CONTROL_STRENGTH, pick_q15());
			write_setting(REG_PRE_GAIN, pick_q15());
			write_setting(REG_AUDIO_WEIGHT, pick_q15());
			write_setting(REG_OUT_GAIN, pick_master());
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				w.control_one = pick_sample();
				w.control_two = pick_sample();
				w.audio_one = pick_sample();
				w.audio_two = pick_sample();
				w.block_last = 1'($urandom);
				issue_word(w, 1'b0, 16'sd0);
				maybe_idle(phase != QUIET_PHASE);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected word: amplified %0d, block_end %0d", amplified, block_end);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (amplified !== want.amplified) begin
					$error("amplified: expected %0d, got %0d", want.amplified, amplified);
					failures++;
				end
				if (block_end !== want.block_end) begin
					$error("block_end: expected %0d, got %0d", want.block_end, block_end);
					failures++;
				end
			end
		end
	end

	// counts cycles where no word, result or register write moves
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done || (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

[filelist.f]
rtl/vca_pkg.sv
rtl/vca_regs.sv
rtl/vca_mix.sv
rtl/vca_gain.sv
rtl/voltage_controlled_amplifier_core.sv
tb/tb_voltage_controlled_amplifier_core.sv
